// ===== rtl/core/sdpb_pkg.sv =====
package sdpb_pkg;

  localparam int WINDOW    = 30;
  localparam int IDX_W     = $clog2(WINDOW);
  localparam int SMP_W     = 10;
  localparam int BIN_W     = 6;
  localparam int TW_W      = 16;
  localparam int PROD_W    = SMP_W + 1 + TW_W;
  localparam int ACC_W     = 31;
  localparam int ABS_W     = ACC_W - 1;
  localparam int SQ_W      = 2 * ABS_W;
  localparam int MAG_W     = SQ_W + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LO = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_HI = 1'd1;

  localparam logic [BIN_W-1:0] BAND_LO_RST = 6'd4;
  localparam logic [BIN_W-1:0] BAND_HI_RST = 6'd6;

  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1073741824;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic             vld;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] k;
    logic [IDX_W-1:0] m;
  } mac_ctl_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] peak;
  } mac_stat_t;

  typedef logic [WINDOW-1:0][TW_W-1:0] tw_tab_t;

  function automatic logic signed [TW_W-1:0] q30_to_q14(input longint v);
    longint unsigned u;
    u = (v < 0) ? 64'd0 : longint'(v);
    return TW_W'((u + 64'd32768) >> 16);
  endfunction

  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic tw_tab_t build_tw(input logic want_sin);
    tw_tab_t                 tab;
    int unsigned             m;
    int unsigned             q;
    int unsigned             r;
    int unsigned             j;
    longint unsigned         a;
    longint unsigned         a2;
    longint unsigned         ts;
    longint unsigned         tc;
    longint unsigned         dv_s;
    longint unsigned         dv_c;
    longint                  s;
    longint                  c;
    logic signed [TW_W-1:0]  cq;
    logic signed [TW_W-1:0]  sq;
    tab = '0;
    for (m = 0; m < WINDOW; m++) begin
      q = 0;
      r = 4 * m;
      while (r >= WINDOW) begin
        r = r - WINDOW;
        q = q + 1;
      end
      a  = udiv64(Q30_HALF_PI * 64'(r), 64'(WINDOW));
      a2 = (a * a) >> 30;
      ts = a;
      tc = Q30_ONE;
      s  = longint'(a);
      c  = longint'(Q30_ONE);
      for (j = 1; j <= 10; j++) begin
        dv_s = 64'((2 * j) * (2 * j + 1));
        dv_c = 64'((2 * j - 1) * (2 * j));
        ts   = udiv64((ts * a2) >> 30, dv_s);
        tc   = udiv64((tc * a2) >> 30, dv_c);
        if (j[0]) begin
          s = s - longint'(ts);
          c = c - longint'(tc);
        end else begin
          s = s + longint'(ts);
          c = c + longint'(tc);
        end
      end
      cq = q30_to_q14(c);
      sq = q30_to_q14(s);
      case (q)
        0: tab[m] = want_sin ? sq : cq;
        1: tab[m] = want_sin ? cq : -sq;
        2: tab[m] = want_sin ? -sq : -cq;
        default: tab[m] = want_sin ? -cq : sq;
      endcase
    end
    return tab;
  endfunction

  localparam tw_tab_t TW_COS = build_tw(1'b0);
  localparam tw_tab_t TW_SIN = build_tw(1'b1);

endpackage

// ===== rtl/core/sdpb_in_if.sv =====
interface sdpb_in_if import sdpb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== rtl/core/sdpb_out_if.sv =====
interface sdpb_out_if import sdpb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BIN_W-1:0] peak_bin;
  logic             in_band;

  modport source (output valid, output peak_bin, output in_band, input ready);
  modport sink (input valid, input peak_bin, input in_band, output ready);
endinterface

// ===== rtl/core/sdpb_cell.sv =====
module sdpb_cell import sdpb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [SMP_W-1:0] d_i,
  output logic [SMP_W-1:0] q_o
);

  logic [SMP_W-1:0] smp_q;
  logic [SMP_W-1:0] smp_d;

  assign smp_d = en_i ? d_i : smp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_q <= '0;
    end else begin
      smp_q <= smp_d;
    end
  end

  assign q_o = smp_q;

endmodule

// ===== rtl/core/sdpb_mac.sv =====
module sdpb_mac import sdpb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SMP_W-1:0] x_i,
  input  mac_ctl_t         ctl_i,
  output mac_stat_t        stat_o
);

  logic signed [TW_W-1:0]   tw_c;
  logic signed [TW_W-1:0]   tw_s;
  logic signed [PROD_W-1:0] x_ext;
  logic signed [PROD_W-1:0] p_re_d;
  logic signed [PROD_W-1:0] p_im_d;
  logic signed [PROD_W-1:0] p_re_q;
  logic signed [PROD_W-1:0] p_im_q;
  mac_ctl_t                 c1_q;

  logic signed [ACC_W-1:0]  acc_re_q;
  logic signed [ACC_W-1:0]  acc_im_q;
  logic signed [ACC_W-1:0]  acc_re_d;
  logic signed [ACC_W-1:0]  acc_im_d;
  logic                     a_done_q;
  logic [IDX_W-1:0]         a_k_q;

  logic [ABS_W-1:0]         abs_re_d;
  logic [ABS_W-1:0]         abs_im_d;
  logic [ABS_W-1:0]         abs_re_q;
  logic [ABS_W-1:0]         abs_im_q;
  logic                     b_vld_q;
  logic [IDX_W-1:0]         b_k_q;

  logic [SQ_W-1:0]          sq_re_d;
  logic [SQ_W-1:0]          sq_im_d;
  logic [SQ_W-1:0]          sq_re_q;
  logic [SQ_W-1:0]          sq_im_q;
  logic                     s_vld_q;
  logic [IDX_W-1:0]         s_k_q;

  logic [MAG_W-1:0]         mag_d;
  logic [MAG_W-1:0]         mag_q;
  logic                     g_vld_q;
  logic [IDX_W-1:0]         g_k_q;

  logic [MAG_W-1:0]         best_q;
  logic [IDX_W-1:0]         peak_q;
  logic                     done_q;
  logic                     upd;

  assign tw_c   = signed'(TW_COS[ctl_i.m]);
  assign tw_s   = signed'(TW_SIN[ctl_i.m]);
  assign x_ext  = signed'(PROD_W'(x_i));
  assign p_re_d = x_ext * PROD_W'(tw_c);
  assign p_im_d = x_ext * PROD_W'(tw_s);

  assign acc_re_d = c1_q.first ? ACC_W'(p_re_q) : acc_re_q + ACC_W'(p_re_q);
  assign acc_im_d = c1_q.first ? ACC_W'(p_im_q) : acc_im_q + ACC_W'(p_im_q);

  assign abs_re_d = acc_re_q[ACC_W-1] ? ABS_W'(-acc_re_q) : ABS_W'(acc_re_q);
  assign abs_im_d = acc_im_q[ACC_W-1] ? ABS_W'(-acc_im_q) : ABS_W'(acc_im_q);

  assign sq_re_d = abs_re_q * abs_re_q;
  assign sq_im_d = abs_im_q * abs_im_q;

  assign mag_d = MAG_W'(sq_re_q) + MAG_W'(sq_im_q);

  assign upd = g_vld_q && ((g_k_q == '0) || (mag_q > best_q));

  always_ff @(posedge clk_i) begin
    p_re_q <= p_re_d;
    p_im_q <= p_im_d;
    if (c1_q.vld) begin
      acc_re_q <= acc_re_d;
      acc_im_q <= acc_im_d;
    end
    a_k_q <= c1_q.k;
    if (a_done_q) begin
      abs_re_q <= abs_re_d;
      abs_im_q <= abs_im_d;
    end
    b_k_q   <= a_k_q;
    sq_re_q <= sq_re_d;
    sq_im_q <= sq_im_d;
    s_k_q   <= b_k_q;
    mag_q   <= mag_d;
    g_k_q   <= s_k_q;
    if (upd) begin
      best_q <= mag_q;
      peak_q <= g_k_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q     <= '0;
      a_done_q <= 1'b0;
      b_vld_q  <= 1'b0;
      s_vld_q  <= 1'b0;
      g_vld_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      c1_q     <= ctl_i;
      a_done_q <= c1_q.vld && c1_q.last;
      b_vld_q  <= a_done_q;
      s_vld_q  <= b_vld_q;
      g_vld_q  <= s_vld_q;
      done_q   <= g_vld_q && (g_k_q == IDX_W'(WINDOW - 1));
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.peak = peak_q;

endmodule

// ===== rtl/core/sliding_dft_peak_band_detector.sv =====
// A sample is taken only in idle; the block takes no new sample until its result
// has been loaded into the output register. The sample chain rotates once per
// multiply-accumulate, and one shared MAC visits every (bin, sample) pair.
// Reset: sample chain cleared to zero, band limits set to 4 and 6, no result pending.
module sliding_dft_peak_band_detector import sdpb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sdpb_in_if.sink              smp_i,
  sdpb_out_if.source           res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BIN_W-1:0]     cfg_wdata_i
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(WINDOW - 1);

  state_e           state_q;
  state_e           state_d;
  logic [IDX_W-1:0] n_q;
  logic [IDX_W-1:0] n_d;
  logic [IDX_W-1:0] k_q;
  logic [IDX_W-1:0] k_d;
  logic [IDX_W-1:0] m_q;
  logic [IDX_W-1:0] m_d;
  logic [IDX_W:0]   m_sum;
  logic [IDX_W-1:0] m_wrap;

  logic [BIN_W-1:0] band_lo_q;
  logic [BIN_W-1:0] band_hi_q;

  logic             out_vld_q;
  logic             out_vld_d;
  logic [BIN_W-1:0] out_peak_q;
  logic             out_band_q;
  logic [BIN_W-1:0] peak_ext;
  logic             load_out;

  logic             take;
  logic             shift_en;
  logic [SMP_W-1:0] smp_chain [WINDOW];
  logic [SMP_W-1:0] smp_feed  [WINDOW];

  mac_ctl_t         ctl;
  mac_stat_t        stat;

  assign smp_i.ready = (state_q == ST_IDLE);
  assign take        = smp_i.valid && smp_i.ready;
  assign shift_en    = take || (state_q == ST_RUN);

  for (genvar i = 0; i < WINDOW; i++) begin : g_chain
    if (i == 0) begin : g_head
      assign smp_feed[i] = take ? smp_i.sample : smp_chain[1];
    end else if (i == WINDOW - 1) begin : g_tail
      assign smp_feed[i] = smp_chain[0];
    end else begin : g_mid
      assign smp_feed[i] = smp_chain[i+1];
    end
    sdpb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (shift_en),
      .d_i    (smp_feed[i]),
      .q_o    (smp_chain[i])
    );
  end

  sdpb_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .x_i    (smp_chain[0]),
    .ctl_i  (ctl),
    .stat_o (stat)
  );

  assign m_sum  = {1'b0, m_q} + {1'b0, k_q};
  assign m_wrap = (m_sum >= (IDX_W+1)'(WINDOW)) ? IDX_W'(m_sum - (IDX_W+1)'(WINDOW))
                                                 : IDX_W'(m_sum);

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    k_d      = k_q;
    m_d      = m_q;
    load_out = 1'b0;
    ctl      = '0;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          n_d     = '0;
          k_d     = '0;
          m_d     = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        ctl.vld   = 1'b1;
        ctl.first = (n_q == '0);
        ctl.last  = (n_q == LAST);
        ctl.k     = k_q;
        ctl.m     = m_q;
        if (n_q == LAST) begin
          n_d = '0;
          m_d = '0;
          k_d = k_q + IDX_W'(1);
          if (k_q == LAST) begin
            state_d = ST_DRAIN;
          end
        end else begin
          n_d = n_q + IDX_W'(1);
          m_d = m_wrap;
        end
      end
      ST_DRAIN: begin
        if (stat.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_vld_q || res_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
      k_q <= '0;
      m_q <= '0;
    end else begin
      n_q <= n_d;
      k_q <= k_d;
      m_q <= m_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_lo_q <= BAND_LO_RST;
      band_hi_q <= BAND_HI_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BAND_LO: band_lo_q <= cfg_wdata_i;
        CFG_BAND_HI: band_hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign peak_ext  = BIN_W'(stat.peak);
  assign out_vld_d = load_out ? 1'b1 : (res_o.ready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_peak_q <= peak_ext;
      out_band_q <= (peak_ext >= band_lo_q) && (peak_ext <= band_hi_q);
    end
  end

  assign res_o.valid    = out_vld_q;
  assign res_o.peak_bin = out_peak_q;
  assign res_o.in_band  = out_band_q;

  a_done_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> (state_q == ST_DRAIN))
    else $error("peak search finished outside drain");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> ((n_q <= LAST) && (k_q <= LAST) && (m_q <= LAST)))
    else $error("sample, bin or twiddle index out of range");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && n_q == LAST && k_q == LAST) |=> (state_q == ST_DRAIN))
    else $error("last bin did not end the sweep");

  a_take_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (state_q == ST_RUN && n_q == '0 && k_q == '0 && m_q == '0))
    else $error("sweep did not start clean after an item");

endmodule

// ===== sim/sliding_dft_peak_band_detector_tb.sv =====
`timescale 1ns / 1ps

module sliding_dft_peak_band_detector_tb;
  import sdpb_pkg::*;

  typedef longint unsigned u64_t;

  localparam u64_t HALF_PI_Q30  = 64'd1686629713;
  localparam u64_t ONE_Q30      = 64'd1073741824;
  localparam int   ITEM_CYCLES  = WINDOW * WINDOW + 8;
  localparam int   STALL_LIMIT  = 10 * ITEM_CYCLES;
  localparam int   DRAIN_CYCLES = ITEM_CYCLES + 100;
  localparam int   N_DIR        = 22;
  localparam int   N_CHUNK      = 56;
  localparam int   MAX_PRINTS   = 40;

  typedef struct packed {
    logic [BIN_W-1:0] peak_bin;
    logic             in_band;
  } peak_t;

  typedef struct packed {
    logic [SMP_W-1:0] sample;
    logic             new_band;
    logic [BIN_W-1:0] lo;
    logic [BIN_W-1:0] hi;
    logic             known;
    logic [BIN_W-1:0] peak_bin;
    logic             in_band;
  } dir_row_t;

  typedef enum int {
    MIX_DENSE,
    MIX_SPARSE,
    MIX_LOW,
    MIX_RAILS
  } mix_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [BIN_W-1:0]     cfg_wdata_i;

  sdpb_in_if  smp ();
  sdpb_out_if res ();

  sliding_dft_peak_band_detector dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp_i       (smp),
    .res_o       (res),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  int               cos_q14 [WINDOW];
  int               sin_q14 [WINDOW];
  logic [SMP_W-1:0] ring [WINDOW];
  int               wr_pos;
  logic [BIN_W-1:0] band_lo;
  logic [BIN_W-1:0] band_hi;
  peak_t            pending [$];
  int               errors;
  int               src_gap_pct;
  int               snk_gap_pct;

  // sample, new band, lo, hi, known, peak_bin, in_band
  dir_row_t dir_rows [N_DIR] = '{
    '{10'd0,    1'b0, 6'd0,  6'd0,  1'b1, 6'd0, 1'b0},
    '{10'd1023, 1'b0, 6'd0,  6'd0,  1'b1, 6'd0, 1'b0},
    '{10'd0,    1'b0, 6'd0,  6'd0,  1'b0, 6'd0, 1'b0},
    '{10'd0,    1'b0, 6'd0,  6'd0,  1'b0, 6'd0, 1'b0},
    '{10'd0,    1'b0, 6'd0,  6'd0,  1'b0, 6'd0, 1'b0},
    '{10'd1023, 1'b0, 6'd0,  6'd0,  1'b0, 6'd0, 1'b0},
    '{10'd1023, 1'b0, 6'd0,  6'd0,  1'b0, 6'd0, 1'b0},
    '{10'd1,    1'b0, 6'd0,  6'd0,  1'b0, 6'd0, 1'b0},
    '{10'd512,  1'b0, 6'd0,  6'd0,  1'b0, 6'd0, 1'b0},
    '{10'd0,    1'b1, 6'd0,  6'd63, 1'b0, 6'd0, 1'b0},
    '{10'd1023, 1'b0, 6'd0,  6'd0,  1'b0, 6'd0, 1'b0},
    '{10'd0,    1'b1, 6'd63, 6'd0,  1'b0, 6'd0, 1'b0},
    '{10'd682,  1'b0, 6'd0,  6'd0,  1'b0, 6'd0, 1'b0},
    '{10'd341,  1'b1, 6'd0,  6'd0,  1'b0, 6'd0, 1'b0},
    '{10'd0,    1'b0, 6'd0,  6'd0,  1'b0, 6'd0, 1'b0},
    '{10'd0,    1'b1, 6'd29, 6'd29, 1'b0, 6'd0, 1'b0},
    '{10'd0,    1'b0, 6'd0,  6'd0,  1'b0, 6'd0, 1'b0},
    '{10'd1023, 1'b1, 6'd63, 6'd63, 1'b0, 6'd0, 1'b0},
    '{10'd0,    1'b1, 6'd30, 6'd63, 1'b0, 6'd0, 1'b0},
    '{10'd0,    1'b0, 6'd0,  6'd0,  1'b0, 6'd0, 1'b0},
    '{10'd1023, 1'b1, 6'd4,  6'd6,  1'b0, 6'd0, 1'b0},
    '{10'd0,    1'b0, 6'd0,  6'd0,  1'b0, 6'd0, 1'b0}
  };

  function automatic int round_q14(input longint v);
    if (v < 0) begin
      return 0;
    end
    return int'((u64_t'(v) + 64'd32768) >> 16);
  endfunction

  function automatic void build_twiddles();
    u64_t   ang;
    u64_t   ang2;
    u64_t   ts;
    u64_t   tc;
    longint s;
    longint c;
    int     quad;
    int     rem;
    int     cq;
    int     sq;
    for (int m = 0; m < WINDOW; m++) begin
      quad = (4 * m) / WINDOW;
      rem  = 4 * m - quad * WINDOW;
      ang  = (HALF_PI_Q30 * u64_t'(rem)) / u64_t'(WINDOW);
      ang2 = (ang * ang) >> 30;
      ts   = ang;
      tc   = ONE_Q30;
      s    = longint'(ang);
      c    = longint'(ONE_Q30);
      for (int j = 1; j <= 10; j++) begin
        ts = ((ts * ang2) >> 30) / u64_t'((2 * j) * (2 * j + 1));
        tc = ((tc * ang2) >> 30) / u64_t'((2 * j - 1) * (2 * j));
        if (j % 2 == 1) begin
          s = s - longint'(ts);
          c = c - longint'(tc);
        end else begin
          s = s + longint'(ts);
          c = c + longint'(tc);
        end
      end
      cq = round_q14(c);
      sq = round_q14(s);
      case (quad)
        0: begin
          cos_q14[m] = cq;
          sin_q14[m] = sq;
        end
        1: begin
          cos_q14[m] = -sq;
          sin_q14[m] = cq;
        end
        2: begin
          cos_q14[m] = -cq;
          sin_q14[m] = -sq;
        end
        default: begin
          cos_q14[m] = sq;
          sin_q14[m] = -cq;
        end
      endcase
    end
  endfunction

  function automatic peak_t predict_peak(input logic [SMP_W-1:0] s);
    int     x [WINDOW];
    int     idx;
    int     peak;
    longint re;
    longint im;
    u64_t   mag;
    u64_t   best;
    peak_t  r;
    wr_pos       = (wr_pos + 1) % WINDOW;
    ring[wr_pos] = s;
    for (int n = 0; n < WINDOW; n++) begin
      x[n] = int'(ring[(wr_pos + n) % WINDOW]);
    end
    best = 0;
    peak = 0;
    for (int k = 0; k < WINDOW; k++) begin
      re = 0;
      im = 0;
      for (int n = 0; n < WINDOW; n++) begin
        idx = (n * k) % WINDOW;
        re  = re + longint'(x[n] * cos_q14[idx]);
        im  = im - longint'(x[n] * sin_q14[idx]);
      end
      mag = u64_t'(re * re) + u64_t'(im * im);
      if (k == 0 || mag > best) begin
        best = mag;
        peak = k;
      end
    end
    r.peak_bin = BIN_W'(peak);
    r.in_band  = (r.peak_bin >= band_lo) && (r.peak_bin <= band_hi);
    return r;
  endfunction

  function automatic logic [SMP_W-1:0] draw_sample(input mix_e mix);
    case (mix)
      MIX_DENSE:  return SMP_W'($urandom_range((1 << SMP_W) - 1));
      MIX_SPARSE: return ($urandom_range(99) < 92) ? '0 : SMP_W'($urandom_range((1 << SMP_W) - 1));
      MIX_LOW:    return SMP_W'($urandom_range(3));
      default:    return ($urandom_range(1) == 1) ? '1 : '0;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < MAX_PRINTS) begin
      $display("mismatch at %0t: %s", $time, what);
    end
    errors++;
  endtask

  task automatic send_sample(input logic [SMP_W-1:0] v, input logic known, input peak_t fixed);
    peak_t pred;
    while ($urandom_range(99) < src_gap_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp.valid  <= 1'b1;
    smp.sample <= v;
    @(posedge clk_i);
    while (!smp.ready) begin
      @(posedge clk_i);
    end
    pred = predict_peak(v);
    pending.push_back(known ? fixed : pred);
  endtask

  task automatic set_band(input logic [BIN_W-1:0] lo, input logic [BIN_W-1:0] hi);
    smp.valid <= 1'b0;
    while (pending.size() != 0) begin
      @(posedge clk_i);
    end
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_BAND_LO;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_BAND_HI;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    band_lo = lo;
    band_hi = hi;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    res.ready <= ($urandom_range(99) >= snk_gap_pct);
  end

  always @(posedge clk_i) begin : check_results
    peak_t want;
    if (res.valid && res.ready) begin
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result peak_bin %0d with nothing pending", res.peak_bin));
      end else begin
        want = pending.pop_front();
        if (res.peak_bin !== want.peak_bin) begin
          report_mismatch($sformatf("peak_bin %0d, want %0d", res.peak_bin, want.peak_bin));
        end
        if (res.in_band !== want.in_band) begin
          report_mismatch($sformatf("in_band %0b, want %0b (peak_bin %0d)",
                                    res.in_band, want.in_band, want.peak_bin));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((smp.valid && smp.ready) || (res.valid && res.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    mix_e             mix;
    logic [BIN_W-1:0] lo;
    logic [BIN_W-1:0] hi;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_BAND_LO;
    cfg_wdata_i = '0;
    smp.valid   = 1'b0;
    smp.sample  = '0;
    errors      = 0;
    src_gap_pct = 14;
    snk_gap_pct = 60;
    mix         = MIX_DENSE;
    build_twiddles();
    for (int n = 0; n < WINDOW; n++) begin
      ring[n] = '0;
    end
    wr_pos  = 0;
    band_lo = BAND_LO_RST;
    band_hi = BAND_HI_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].new_band) begin
        set_band(dir_rows[i].lo, dir_rows[i].hi);
      end
      send_sample(dir_rows[i].sample, dir_rows[i].known,
                  '{peak_bin: dir_rows[i].peak_bin, in_band: dir_rows[i].in_band});
    end

    for (int ph = 0; ph < 3; ph++) begin
      for (int ch = 0; ch < 3; ch++) begin
        lo = ($urandom_range(2) == 0) ? '0 : BIN_W'($urandom_range(31));
        hi = ($urandom_range(3) == 0) ? '1 : BIN_W'($urandom_range(63));
        set_band(lo, hi);
        case (ph)
          0: begin
            src_gap_pct = 14;
            snk_gap_pct = 60;
          end
          1: begin
            src_gap_pct = 60;
            snk_gap_pct = 14;
          end
          default: begin
            src_gap_pct = 0;
            snk_gap_pct = 0;
          end
        endcase
        for (int i = 0; i < N_CHUNK; i++) begin
          if (i % 28 == 0) begin
            mix = mix_e'($urandom_range(3));
          end
          send_sample(draw_sample(mix), 1'b0, '0);
        end
      end
    end

    smp.valid <= 1'b0;
    while (pending.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sdpb_pkg.sv
rtl/core/sdpb_in_if.sv
rtl/core/sdpb_out_if.sv
rtl/core/sdpb_cell.sv
rtl/core/sdpb_mac.sv
rtl/core/sliding_dft_peak_band_detector.sv
sim/sliding_dft_peak_band_detector_tb.sv
